// ===== rtl/dsg_pkg.sv =====
// dsg_pkg: constants, register indexes and widths shared by the damped sinusoid generator
// no dependencies
package dsg_pkg;

   localparam int SUM_W = 34;

   localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
   localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
   localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
   localparam logic [29:0] LN2_Q30    = 30'd744261118;
   localparam logic [30:0] EXP_CLAMP  = 31'h4000_0000;

   localparam int SIN_TERMS = 8;
   localparam int EXP_TERMS = 13;

   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_PHASE_STEP  = 3'd0,
      REG_PHASE_OFS   = 3'd1,
      REG_DECAY_RATE  = 3'd2,
      REG_PULSE_START = 3'd3,
      REG_PEAK_AMP    = 3'd4,
      REG_OFFSET_LVL  = 3'd5,
      REG_FLOOR_MODE  = 3'd6
   } reg_index_type;

endpackage

// ===== rtl/damped_sinusoid_generator.sv =====
// damped_sinusoid_generator: top level, register file, output product and saturation
// depends on dsg_pkg, dsg_sine and dsg_env
// an accepted time word passes the sine pipeline, the envelope pipeline, the product registers and the output register
// throughput: one word per cycle; the whole pipeline holds only while the output
// register holds a word that is stalled, otherwise every stage moves on each cycle
// reset: synchronous, clears all valid bits and loads register reset values
module damped_sinusoid_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [31:0]                        req_sample_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [31:0]                 rsp_sample_value,
   output logic                               rsp_after_pulse,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dsg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import dsg_pkg::*;

   logic [31:0] step_ff, step_in, ofs_ff, ofs_in, decay_ff, decay_in;
   logic [31:0] pulse_ff, pulse_in, amp_ff, amp_in, lvl_ff, lvl_in;
   logic        floor_ff, floor_in;
   logic        wr_en;
   reg_index_type idx;

   logic        en;
   logic        after_w;
   logic [31:0] dt_w;

   logic        s_v, s_neg;
   logic [30:0] s_sin;
   logic [32:0] s_side;
   logic        e_v;
   logic [30:0] e_env;
   logic [32:0] e_side;

   logic        p1_v_ff, p1_v_in, p2_v_ff, p2_v_in, rsp_v_ff, rsp_v_in;
   logic [30:0] m_ff, m_in;
   logic        p1_neg_ff, p1_neg_in, p1_after_ff, p1_after_in;
   logic [31:0] mag_ff, mag_in;
   logic        p2_neg_ff, p2_neg_in, p2_after_ff, p2_after_in;
   logic [31:0] val_ff, val_in;
   logic        rsp_after_ff, rsp_after_in;

   logic [61:0]             es_w;
   logic [31:0]             amag_w;
   logic [62:0]             am_w;
   logic signed [SUM_W-1:0] total_w;
   logic [31:0]             sat_w;

   // register file
   assign idx   = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      step_in  = step_ff;
      ofs_in   = ofs_ff;
      decay_in = decay_ff;
      pulse_in = pulse_ff;
      amp_in   = amp_ff;
      lvl_in   = lvl_ff;
      floor_in = floor_ff;
      csr_prdata = '0;
      case (idx)
         REG_PHASE_STEP:  csr_prdata = step_ff;
         REG_PHASE_OFS:   csr_prdata = ofs_ff;
         REG_DECAY_RATE:  csr_prdata = decay_ff;
         REG_PULSE_START: csr_prdata = pulse_ff;
         REG_PEAK_AMP:    csr_prdata = amp_ff;
         REG_OFFSET_LVL:  csr_prdata = lvl_ff;
         REG_FLOOR_MODE:  csr_prdata = {31'b0, floor_ff};
         default:         csr_prdata = '0;
      endcase
      if (wr_en) begin
         case (idx)
            REG_PHASE_STEP:  step_in  = csr_pwdata;
            REG_PHASE_OFS:   ofs_in   = csr_pwdata;
            REG_DECAY_RATE:  decay_in = csr_pwdata;
            REG_PULSE_START: pulse_in = csr_pwdata;
            REG_PEAK_AMP:    amp_in   = csr_pwdata;
            REG_OFFSET_LVL:  lvl_in   = csr_pwdata;
            REG_FLOOR_MODE:  floor_in = csr_pwdata[0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         ofs_ff   <= '0;
         decay_ff <= '0;
         pulse_ff <= '0;
         amp_ff   <= 32'h0001_0000;
         lvl_ff   <= '0;
         floor_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         ofs_ff   <= ofs_in;
         decay_ff <= decay_in;
         pulse_ff <= pulse_in;
         amp_ff   <= amp_in;
         lvl_ff   <= lvl_in;
         floor_ff <= floor_in;
      end
   end

   assign csr_pready = 1'b1;

   // pipeline advances unless the output word is stalled
   assign en        = !rsp_v_ff || !rsp_stall;
   assign req_stall = !en;

   assign after_w = (req_sample_time >= pulse_ff);
   assign dt_w    = req_sample_time - pulse_ff;

   dsg_sine #(
      .SIDEW (33)
   ) u_sine (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .in_time      (req_sample_time),
      .phase_step   (step_ff),
      .phase_offset (ofs_ff),
      .in_side      ({after_w, dt_w}),
      .out_valid    (s_v),
      .out_sin      (s_sin),
      .out_neg      (s_neg),
      .out_side     (s_side)
   );

   dsg_env #(
      .SIDEW (33)
   ) u_env (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s_v),
      .in_dt      (s_side[31:0]),
      .decay_rate (decay_ff),
      .in_side    ({s_side[32], s_neg, s_sin}),
      .out_valid  (e_v),
      .out_env    (e_env),
      .out_side   (e_side)
   );

   always_comb begin
      es_w        = 62'(e_env) * 62'(e_side[30:0]);
      p1_v_in     = e_v;
      m_in        = es_w[60:30];
      p1_neg_in   = e_side[31];
      p1_after_in = e_side[32];

      amag_w      = amp_ff[31] ? 32'(-amp_ff) : amp_ff;
      am_w        = 63'(amag_w) * 63'(m_ff);
      p2_v_in     = p1_v_ff;
      mag_in      = am_w[61:30];
      p2_neg_in   = p1_neg_ff ^ amp_ff[31];
      p2_after_in = p1_after_ff;

      total_w = $signed(SUM_W'($signed(lvl_ff)));
      if (p2_after_ff) begin
         if (p2_neg_ff) begin
            total_w = total_w - $signed(SUM_W'(mag_ff));
         end else begin
            total_w = total_w + $signed(SUM_W'(mag_ff));
         end
      end
      if (total_w > $signed(SUM_W'(32'h7FFF_FFFF))) begin
         sat_w = 32'h7FFF_FFFF;
      end else if (total_w < -$signed(SUM_W'(33'h0_8000_0000))) begin
         sat_w = 32'h8000_0000;
      end else begin
         sat_w = total_w[31:0];
      end
      rsp_v_in     = p2_v_ff;
      val_in       = floor_ff ? {sat_w[31:16], 16'h0000} : sat_w;
      rsp_after_in = p2_after_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff      <= p1_v_in;
         m_ff         <= m_in;
         p1_neg_ff    <= p1_neg_in;
         p1_after_ff  <= p1_after_in;
         p2_v_ff      <= p2_v_in;
         mag_ff       <= mag_in;
         p2_neg_ff    <= p2_neg_in;
         p2_after_ff  <= p2_after_in;
         rsp_v_ff     <= rsp_v_in;
         val_ff       <= val_in;
         rsp_after_ff <= rsp_after_in;
      end
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_sample_value = $signed(val_ff);
   assign rsp_after_pulse  = rsp_after_ff;

`ifndef SYNTH
   a_baseline_before_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_after_pulse |->
         rsp_sample_value == (floor_ff ? {lvl_ff[31:16], 16'h0000} : lvl_ff))
      else $error("baseline mismatch before pulse start");

   a_floor_clears_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && floor_ff |-> rsp_sample_value[15:0] == 16'h0000)
      else $error("fraction left in floor mode");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked output");
`endif

endmodule

// ===== rtl/dsg_term.sv =====
// dsg_term: one series term over three stages (product, reciprocal multiply, correct and add)
// depends on dsg_pkg
module dsg_term #(
   parameter int XW    = 32,
   parameter int D     = 6,
   parameter bit SUB   = 1'b1,
   parameter int SIDEW = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [XW-1:0]                    in_term,
   input  logic [31:0]                      in_mul,
   input  logic signed [dsg_pkg::SUM_W-1:0] in_sum,
   input  logic [SIDEW-1:0]                 in_side,
   output logic                             out_valid,
   output logic [XW-1:0]                    out_term,
   output logic [31:0]                      out_mul,
   output logic signed [dsg_pkg::SUM_W-1:0] out_sum,
   output logic [SIDEW-1:0]                 out_side
);
   import dsg_pkg::*;

   localparam int FL = $clog2(D + 1) - 1;
   localparam int SH = XW + FL;
   localparam logic [63:0] MFULL = (64'd1 << SH) / 64'(D);
   localparam logic [XW:0] MREC = MFULL[XW:0];
   localparam logic [XW-1:0] DV = XW'(D);

   logic                    v1_ff, v2_ff, v3_ff;
   logic                    v1_in, v2_in, v3_in;
   logic [XW-1:0]           x1_ff, x1_in, x2_ff, x2_in, term3_ff, term3_in;
   logic [2*XW:0]           qm2_ff, qm2_in;
   logic [31:0]             mul1_ff, mul2_ff, mul3_ff;
   logic [31:0]             mul1_in, mul2_in, mul3_in;
   logic signed [SUM_W-1:0] sum1_ff, sum2_ff, sum3_ff;
   logic signed [SUM_W-1:0] sum1_in, sum2_in, sum3_in;
   logic [SIDEW-1:0]        side1_ff, side2_ff, side3_ff;
   logic [SIDEW-1:0]        side1_in, side2_in, side3_in;

   logic [XW+31:0] prod1;
   logic [2*XW:0]  shifted;
   logic [XW-1:0]  q0, rem, qfix;

   always_comb begin
      prod1    = (XW+32)'(in_term) * (XW+32)'(in_mul);
      v1_in    = in_valid;
      x1_in    = prod1[XW+29:30];
      mul1_in  = in_mul;
      sum1_in  = in_sum;
      side1_in = in_side;

      v2_in    = v1_ff;
      x2_in    = x1_ff;
      qm2_in   = (2*XW+1)'(x1_ff) * (2*XW+1)'(MREC);
      mul2_in  = mul1_ff;
      sum2_in  = sum1_ff;
      side2_in = side1_ff;

      // reciprocal estimate is exact or one low
      shifted  = qm2_ff >> SH;
      q0       = shifted[XW-1:0];
      rem      = x2_ff - XW'(q0 * DV);
      qfix     = (rem >= DV) ? q0 + XW'(1) : q0;
      v3_in    = v2_ff;
      term3_in = qfix;
      mul3_in  = mul2_ff;
      sum3_in  = SUB ? sum2_ff - $signed(SUM_W'(qfix)) : sum2_ff + $signed(SUM_W'(qfix));
      side3_in = side2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= v1_in;
         x1_ff    <= x1_in;
         mul1_ff  <= mul1_in;
         sum1_ff  <= sum1_in;
         side1_ff <= side1_in;
         v2_ff    <= v2_in;
         x2_ff    <= x2_in;
         qm2_ff   <= qm2_in;
         mul2_ff  <= mul2_in;
         sum2_ff  <= sum2_in;
         side2_ff <= side2_in;
         v3_ff    <= v3_in;
         term3_ff <= term3_in;
         mul3_ff  <= mul3_in;
         sum3_ff  <= sum3_in;
         side3_ff <= side3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_term  = term3_ff;
   assign out_mul   = mul3_ff;
   assign out_sum   = sum3_ff;
   assign out_side  = side3_ff;

endmodule

// ===== rtl/dsg_sine.sv =====
// dsg_sine: phase from time times step plus offset, pipelined Taylor sine, magnitude in Q30 plus sign
// depends on dsg_pkg and dsg_term
module dsg_sine #(
   parameter int SIDEW = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [31:0]      in_time,
   input  logic [31:0]      phase_step,
   input  logic [31:0]      phase_offset,
   input  logic [SIDEW-1:0] in_side,
   output logic             out_valid,
   output logic [30:0]      out_sin,
   output logic             out_neg,
   output logic [SIDEW-1:0] out_side
);
   import dsg_pkg::*;

   localparam int TS = SIDEW + 1;

   logic             f1_v_ff, f2_v_ff, f3_v_ff, c_v_ff;
   logic             f1_v_in, f2_v_in, f3_v_in, c_v_in;
   logic [31:0]      theta_ff, theta_in;
   logic [30:0]      a2r_ff, a2r_in, a3_ff, a3_in;
   logic [31:0]      a2sq_ff, a2sq_in;
   logic             neg2_ff, neg2_in, neg3_ff, neg3_in, c_neg_ff, c_neg_in;
   logic [SIDEW-1:0] side1_ff, side1_in, side2_ff, side2_in, side3_ff, side3_in;
   logic [SIDEW-1:0] c_side_ff, c_side_in;
   logic [30:0]      c_sin_ff, c_sin_in;

   logic [30:0] r_w;
   logic [61:0] ra_w, aa_w;

   logic                    t_v    [SIN_TERMS+1];
   logic [31:0]             t_term [SIN_TERMS+1];
   logic [31:0]             t_mul  [SIN_TERMS+1];
   logic signed [SUM_W-1:0] t_sum  [SIN_TERMS+1];
   logic [TS-1:0]           t_side [SIN_TERMS+1];

   always_comb begin
      f1_v_in  = in_valid;
      theta_in = 32'(in_time * phase_step) + phase_offset;
      side1_in = in_side;

      // mirror odd quadrants
      r_w      = theta_ff[30] ? Q30_ONE - {1'b0, theta_ff[29:0]} : {1'b0, theta_ff[29:0]};
      ra_w     = 62'(r_w) * 62'(HALFPI_Q30);
      f2_v_in  = f1_v_ff;
      a2r_in   = ra_w[60:30];
      neg2_in  = theta_ff[31];
      side2_in = side1_ff;

      aa_w     = 62'(a2r_ff) * 62'(a2r_ff);
      f3_v_in  = f2_v_ff;
      a3_in    = a2r_ff;
      a2sq_in  = aa_w[61:30];
      neg3_in  = neg2_ff;
      side3_in = side2_ff;
   end

   assign t_v[0]    = f3_v_ff;
   assign t_term[0] = {1'b0, a3_ff};
   assign t_mul[0]  = a2sq_ff;
   assign t_sum[0]  = $signed(SUM_W'(a3_ff));
   assign t_side[0] = {neg3_ff, side3_ff};

   for (genvar k = 1; k <= SIN_TERMS; k++) begin : g_term
      dsg_term #(
         .XW    (32),
         .D     ((2 * k) * (2 * k + 1)),
         .SUB   ((k % 2) == 1),
         .SIDEW (TS)
      ) u_term (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (t_v[k-1]),
         .in_term   (t_term[k-1]),
         .in_mul    (t_mul[k-1]),
         .in_sum    (t_sum[k-1]),
         .in_side   (t_side[k-1]),
         .out_valid (t_v[k]),
         .out_term  (t_term[k]),
         .out_mul   (t_mul[k]),
         .out_sum   (t_sum[k]),
         .out_side  (t_side[k])
      );
   end

   always_comb begin
      c_v_in    = t_v[SIN_TERMS];
      c_neg_in  = t_side[SIN_TERMS][TS-1];
      c_side_in = t_side[SIN_TERMS][SIDEW-1:0];
      if (t_sum[SIN_TERMS] < 0) begin
         c_sin_in = '0;
      end else if (t_sum[SIN_TERMS] > $signed(SUM_W'(Q30_ONE))) begin
         c_sin_in = Q30_ONE;
      end else begin
         c_sin_in = t_sum[SIN_TERMS][30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
         c_v_ff  <= 1'b0;
      end else if (en) begin
         f1_v_ff   <= f1_v_in;
         theta_ff  <= theta_in;
         side1_ff  <= side1_in;
         f2_v_ff   <= f2_v_in;
         a2r_ff    <= a2r_in;
         neg2_ff   <= neg2_in;
         side2_ff  <= side2_in;
         f3_v_ff   <= f3_v_in;
         a3_ff     <= a3_in;
         a2sq_ff   <= a2sq_in;
         neg3_ff   <= neg3_in;
         side3_ff  <= side3_in;
         c_v_ff    <= c_v_in;
         c_sin_ff  <= c_sin_in;
         c_neg_ff  <= c_neg_in;
         c_side_ff <= c_side_in;
      end
   end

   assign out_valid = c_v_ff;
   assign out_sin   = c_sin_ff;
   assign out_neg   = c_neg_ff;
   assign out_side  = c_side_ff;

endmodule

// ===== rtl/dsg_env.sv =====
// dsg_env: pipelined exponential decay envelope, exp(-dt*rate) in Q30
// depends on dsg_pkg and dsg_term
module dsg_env #(
   parameter int SIDEW = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [31:0]      in_dt,
   input  logic [31:0]      decay_rate,
   input  logic [SIDEW-1:0] in_side,
   output logic             out_valid,
   output logic [30:0]      out_env,
   output logic [SIDEW-1:0] out_side
);
   import dsg_pkg::*;

   localparam int TS = SIDEW + 6;

   logic             e1_v_ff, e2_v_ff, e3_v_ff, c_v_ff;
   logic             e1_v_in, e2_v_in, e3_v_in, c_v_in;
   logic [63:0]      x_ff, x_in;
   logic [30:0]      y_ff, y_in;
   logic [29:0]      z_ff, z_in;
   logic [4:0]       n_ff, n_in;
   logic             zero_ff, zero_in;
   logic [SIDEW-1:0] side1_ff, side1_in, side2_ff, side2_in, side3_ff, side3_in;
   logic [SIDEW-1:0] c_side_ff, c_side_in;
   logic [30:0]      c_env_ff, c_env_in;

   logic [30:0] xc_w;
   logic [61:0] xy_w;
   logic [53:0] fz_w;

   logic                    t_v    [EXP_TERMS+1];
   logic [30:0]             t_term [EXP_TERMS+1];
   logic [31:0]             t_mul  [EXP_TERMS+1];
   logic signed [SUM_W-1:0] t_sum  [EXP_TERMS+1];
   logic [TS-1:0]           t_side [EXP_TERMS+1];

   always_comb begin
      e1_v_in  = in_valid;
      x_in     = 64'(in_dt) * 64'(decay_rate);
      side1_in = in_side;

      // exponent clamped at 64 nepers
      xc_w     = (x_ff > 64'(EXP_CLAMP)) ? EXP_CLAMP : x_ff[30:0];
      xy_w     = 62'(xc_w) * 62'(LOG2E_Q30);
      e2_v_in  = e1_v_ff;
      y_in     = xy_w[60:30];
      side2_in = side1_ff;

      fz_w     = 54'(y_ff[23:0]) * 54'(LN2_Q30);
      e3_v_in  = e2_v_ff;
      z_in     = fz_w[53:24];
      n_in     = y_ff[28:24];
      zero_in  = |y_ff[30:29];
      side3_in = side2_ff;
   end

   assign t_v[0]    = e3_v_ff;
   assign t_term[0] = Q30_ONE;
   assign t_mul[0]  = {2'b00, z_ff};
   assign t_sum[0]  = $signed(SUM_W'(Q30_ONE));
   assign t_side[0] = {zero_ff, n_ff, side3_ff};

   for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
      dsg_term #(
         .XW    (31),
         .D     (k),
         .SUB   ((k % 2) == 1),
         .SIDEW (TS)
      ) u_term (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (t_v[k-1]),
         .in_term   (t_term[k-1]),
         .in_mul    (t_mul[k-1]),
         .in_sum    (t_sum[k-1]),
         .in_side   (t_side[k-1]),
         .out_valid (t_v[k]),
         .out_term  (t_term[k]),
         .out_mul   (t_mul[k]),
         .out_sum   (t_sum[k]),
         .out_side  (t_side[k])
      );
   end

   always_comb begin
      c_v_in    = t_v[EXP_TERMS];
      c_side_in = t_side[EXP_TERMS][SIDEW-1:0];
      if (t_side[EXP_TERMS][TS-1]) begin
         c_env_in = '0;
      end else begin
         c_env_in = t_sum[EXP_TERMS][30:0] >> t_side[EXP_TERMS][TS-2:SIDEW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
         e3_v_ff <= 1'b0;
         c_v_ff  <= 1'b0;
      end else if (en) begin
         e1_v_ff   <= e1_v_in;
         x_ff      <= x_in;
         side1_ff  <= side1_in;
         e2_v_ff   <= e2_v_in;
         y_ff      <= y_in;
         side2_ff  <= side2_in;
         e3_v_ff   <= e3_v_in;
         z_ff      <= z_in;
         n_ff      <= n_in;
         zero_ff   <= zero_in;
         side3_ff  <= side3_in;
         c_v_ff    <= c_v_in;
         c_env_ff  <= c_env_in;
         c_side_ff <= c_side_in;
      end
   end

   assign out_valid = c_v_ff;
   assign out_env   = c_env_ff;
   assign out_side  = c_side_ff;

endmodule

// ===== tb/sv/damped_sinusoid_generator_tb.sv =====
// damped_sinusoid_generator_tb: self-checking testbench for the damped sinusoid generator
// depends on dsg_pkg and damped_sinusoid_generator; directed table first, then random phases
// checked against a fixed-point predictor of the waveform
module damped_sinusoid_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dsg_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PHASES = 8;
   localparam int WORDS_PER_PHASE = 200;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_sample_time = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_sample_value;
   logic rsp_after_pulse;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   damped_sinusoid_generator i_dut (.*);

   typedef struct {
      logic [31:0] value;
      logic after;
   } sample_type;

   typedef struct {
      bit is_cfg;
      logic [2:0] idx;
      logic [31:0] data;
      bit chk;
      logic [31:0] exp_value;
      bit exp_after;
   } vector_type;

   // shadow copy of the register file
   logic [31:0] step_r, ofs_r, decay_r, start_r, amp_r, level_r;
   logic floor_r;

   sample_type pending_samples[$];
   int mismatches = 0;
   int words_sent = 0;
   int words_seen = 0;
   int cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] sine_mag(input logic [31:0] theta);
      logic [63:0] r, a, a2, term;
      longint sum;
      r = {34'd0, theta[29:0]};
      if (theta[30]) r = ONE_Q30 - r;
      a = (r * 64'(HALFPI_Q30)) >> 30;
      a2 = (a * a) >> 30;
      term = a;
      sum = longint'(a);
      for (int k = 1; k <= SIN_TERMS; k++) begin
         term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      return 64'(sum);
   endfunction

   function automatic logic [63:0] envelope(input logic [31:0] dt);
      logic [63:0] x, y, n, f, z, term, sum;
      x = 64'(dt) * 64'(decay_r);
      if (x > (64'd64 << 24)) x = 64'd64 << 24;
      y = (x * 64'(LOG2E_Q30)) >> 30;
      n = y >> 24;
      f = y & 64'hFF_FFFF;
      if (n >= 32) return 64'd0;
      z = (f * 64'(LN2_Q30)) >> 24;
      term = ONE_Q30;
      sum = ONE_Q30;
      for (int k = 1; k <= EXP_TERMS; k++) begin
         term = ((term * z) >> 30) / 64'(k);
         if (k % 2 == 1) sum -= term;
         else sum += term;
      end
      return sum >> n;
   endfunction

   function automatic sample_type predict_sample(input logic [31:0] t);
      sample_type s;
      longint total;
      logic [31:0] theta;
      logic [63:0] smag, env, amag, m, mag;
      bit amp_neg;
      total = longint'(signed'(level_r));
      s.after = (t >= start_r);
      if (s.after) begin
         theta = t * step_r + ofs_r;
         smag = sine_mag(theta);
         env = envelope(t - start_r);
         amp_neg = amp_r[31];
         amag = amp_neg ? 64'(-longint'(signed'(amp_r))) : 64'(amp_r);
         m = (env * smag) >> 30;
         mag = (amag * m) >> 30;
         // sine is negative in the second half turn
         if (amp_neg != theta[31]) total -= longint'(mag);
         else total += longint'(mag);
      end
      if (total > 64'sh7FFF_FFFF) total = 64'sh7FFF_FFFF;
      if (total < -64'sh8000_0000) total = -64'sh8000_0000;
      s.value = total[31:0];
      if (floor_r) s.value[15:0] = '0;
      return s;
   endfunction

   // random gap: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(input logic [31:0] t, input bit typed, input sample_type typed_exp);
      int gap;
      sample_type expect_s;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_time <= t;
      do @(posedge clock); while (req_stall);
      expect_s = typed ? typed_exp : predict_sample(t);
      pending_samples.insert(pending_samples.size(), expect_s);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_PHASE_STEP:  step_r = data;
         REG_PHASE_OFS:   ofs_r = data;
         REG_DECAY_RATE:  decay_r = data;
         REG_PULSE_START: start_r = data;
         REG_PEAK_AMP:    amp_r = data;
         REG_OFFSET_LVL:  level_r = data;
         REG_FLOOR_MODE:  floor_r = data[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_extreme(input logic [31:0] lo, input logic [31:0] hi);
      case ($urandom_range(0, 4))
         0: return lo;
         1: return hi;
         default: return $urandom;
      endcase
   endfunction

   vector_type vectors[] = '{
      // after reset: zero phase, sine is zero
      '{0, REG_UNUSED, 32'h0000_0000, 1, 32'h0000_0000, 1},
      '{0, REG_UNUSED, 32'hFFFF_FFFF, 1, 32'h0000_0000, 1},
      // before pulse the baseline passes through
      '{1, REG_PULSE_START, 32'd1000, 0, 0, 0},
      '{1, REG_OFFSET_LVL, 32'h0001_2345, 0, 0, 0},
      '{0, REG_UNUSED, 32'd999, 1, 32'h0001_2345, 0},
      '{0, REG_UNUSED, 32'd0, 1, 32'h0001_2345, 0},
      '{1, REG_FLOOR_MODE, 32'd1, 0, 0, 0},
      '{0, REG_UNUSED, 32'd5, 1, 32'h0001_0000, 0},
      // quarter turn, full amplitude, no decay: positive saturation, floored
      '{1, REG_OFFSET_LVL, 32'h7FFF_FFFF, 0, 0, 0},
      '{1, REG_PEAK_AMP, 32'h7FFF_FFFF, 0, 0, 0},
      '{1, REG_PHASE_OFS, 32'h4000_0000, 0, 0, 0},
      '{0, REG_UNUSED, 32'd1000, 1, 32'h7FFF_0000, 1},
      '{1, REG_FLOOR_MODE, 32'd0, 0, 0, 0},
      '{0, REG_UNUSED, 32'd1000, 1, 32'h7FFF_FFFF, 1},
      // most negative amplitude and baseline: negative saturation
      '{1, REG_OFFSET_LVL, 32'h8000_0000, 0, 0, 0},
      '{1, REG_PEAK_AMP, 32'h8000_0000, 0, 0, 0},
      '{0, REG_UNUSED, 32'd2000, 1, 32'h8000_0000, 1},
      // huge decay kills the envelope at once
      '{1, REG_OFFSET_LVL, 32'd0, 0, 0, 0},
      '{1, REG_DECAY_RATE, 32'hFFFF_FFFF, 0, 0, 0},
      '{0, REG_UNUSED, 32'd1001, 1, 32'h0000_0000, 1},
      '{0, REG_UNUSED, 32'hFFFF_FFFF, 1, 32'h0000_0000, 1},
      // extreme steps, moderate decay, out-of-range write ignored
      '{1, REG_DECAY_RATE, 32'h0000_4000, 0, 0, 0},
      '{1, REG_PHASE_STEP, 32'h8000_0000, 0, 0, 0},
      '{1, REG_UNUSED, 32'hDEAD_BEEF, 0, 0, 0},
      '{0, REG_UNUSED, 32'd1003, 0, 0, 0},
      '{1, REG_PHASE_STEP, 32'h7FFF_FFFF, 0, 0, 0},
      '{0, REG_UNUSED, 32'd1777, 0, 0, 0},
      '{0, REG_UNUSED, 32'h8000_0001, 0, 0, 0}
   };

   // result side back-pressure: runs of free and stalled cycles
   initial begin
      int run;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         rsp_stall <= (run > 1) ? ($urandom_range(0, 2) == 0) : 1'b0;
         repeat (run) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      sample_type exp_s;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycles,
                  pending_samples.size());
         $display("damped_sinusoid_generator_tb: done, errors");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: value %h after %b", rsp_sample_value, rsp_after_pulse);
         end else begin
            exp_s = pending_samples.pop_front();
            if (rsp_sample_value !== exp_s.value || rsp_after_pulse !== exp_s.after) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch word %0d: value %h/%h after %b/%b (expected/actual)",
                           words_seen, exp_s.value, rsp_sample_value, exp_s.after,
                           rsp_after_pulse);
            end
         end
      end
   end

   initial begin
      sample_type typed_exp;
      logic [31:0] t;
      step_r = '0; ofs_r = '0; decay_r = '0; start_r = '0;
      amp_r = 32'd65536; level_r = '0; floor_r = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (vectors[i]) begin
         if (vectors[i].is_cfg) begin
            drain();
            write_reg(vectors[i].idx, vectors[i].data);
         end else begin
            typed_exp.value = vectors[i].exp_value;
            typed_exp.after = vectors[i].exp_after;
            send_word(vectors[i].data, vectors[i].chk, typed_exp);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         write_reg(REG_PHASE_STEP, pick_extreme(32'h8000_0000, 32'h7FFF_FFFF));
         write_reg(REG_PHASE_OFS, pick_extreme(32'h0, 32'hFFFF_FFFF));
         // shifted so the envelope spans from flat to gone
         write_reg(REG_DECAY_RATE, (p == 0) ? 32'h0 : $urandom >> $urandom_range(0, 31));
         write_reg(REG_PULSE_START, pick_extreme(32'h0, 32'hFFFF_FFFF));
         write_reg(REG_PEAK_AMP, pick_extreme(32'h8000_0000, 32'h7FFF_FFFF));
         write_reg(REG_OFFSET_LVL, ($urandom_range(0, 3) == 0) ? pick_extreme(32'h8000_0000,
                   32'h7FFF_FFFF) : $urandom >> $urandom_range(8, 31));
         write_reg(REG_FLOOR_MODE, p % 2);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            case ($urandom_range(0, 9))
               0, 1: t = $urandom;
               2: t = start_r - $urandom_range(1, 16);
               default: t = start_r + $urandom_range(0, 4095);
            endcase
            send_word(t, 1'b0, typed_exp);
         end
      end

      drain();
      repeat (200) @(negedge clock);
      $display("sent %0d time words over %0d directed rows and %0d random register settings",
               words_sent, vectors.size(), RANDOM_PHASES);
      $display("received %0d result words, %0d mismatches", words_seen, mismatches);
      if (mismatches == 0 && pending_samples.size() == 0)
         $display("damped_sinusoid_generator_tb: done, clean");
      else
         $display("damped_sinusoid_generator_tb: done, errors");
      $finish;
   end

endmodule

// ===== damped_sinusoid_generator.f =====
rtl/dsg_pkg.sv
rtl/dsg_term.sv
rtl/dsg_sine.sv
rtl/dsg_env.sv
rtl/damped_sinusoid_generator.sv
tb/sv/damped_sinusoid_generator_tb.sv
